[rtl/core/bcc_pkg.sv]
package bcc_pkg;

    localparam int HOLD_WIDTH_DEF = 16;
    localparam int HOLD_TICKS_W   = 16;
    localparam int WINDOW_W       = 8;
    localparam int STROKE_W       = 2;

    // hold count thresholds
    localparam int PRESS_MIN = 15;
    localparam int TAP_MIN   = 3;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;
    localparam int IN_W   = 8;
    localparam int OUT_W  = 8;

    typedef enum logic [1:0] {
        REG_ACTIVE_LEVEL = 2'd0,
        REG_HOLD_TICKS   = 2'd1,
        REG_DOUBLE_WIN   = 2'd2,
        REG_SATURATE     = 2'd3
    } t_reg_idx;

    localparam logic                    RST_ACTIVE_LEVEL = 1'b0;
    localparam logic [HOLD_TICKS_W-1:0] RST_HOLD_TICKS   = 16'd200;
    localparam logic [WINDOW_W-1:0]     RST_DOUBLE_WIN   = 8'd25;
    localparam logic                    RST_SATURATE     = 1'b1;

endpackage

[rtl/core/button_click_classifier_unit.sv]
// channel  | dir | fields (tdata, lowest bit first)
// s_*      | in  | pin_level, clear_short, clear_long, clear_double, 4'b0
// m_*      | out | short_click, long_press, double_click, pressing, 4'b0
// apb      | in  | 0 active_level, 1 hold_ticks, 2 double_window, 3 saturate_at_hold
//
// one word per cycle while s_tready is high: the click state advances when a word
// is accepted and the result lands in the output register on the same edge.
// s_tready stays high while the output register is empty or being drained,
// so a stalled consumer only holds off the input once a result is waiting.
// i_rst_n is synchronous: state and result valid clear, registers take defaults.
module button_click_classifier_unit #(
    parameter int HOLD_WIDTH = bcc_pkg::HOLD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // pin_level, clear_short, clear_long, clear_double, zero pad
    input  logic [bcc_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // short_click, long_press, double_click, pressing, zero pad
    output logic [bcc_pkg::OUT_W-1:0]   m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bcc_pkg::DATA_W-1:0]  pwdata,
    output logic [bcc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import bcc_pkg::*;

    localparam int CW = (HOLD_WIDTH > HOLD_TICKS_W) ? HOLD_WIDTH : HOLD_TICKS_W;

    // configuration
    logic                    r_active_level;
    logic [HOLD_TICKS_W-1:0] r_hold_ticks;
    logic [WINDOW_W-1:0]     r_double_win;
    logic                    r_saturate;

    // click state
    logic                  r_level_now, n_level_now;
    logic [HOLD_WIDTH-1:0] r_hold, n_hold;
    logic [STROKE_W-1:0]   r_stroke, n_stroke;
    logic                  r_lock, n_lock;
    logic [WINDOW_W-1:0]   r_gap, n_gap;
    logic                  r_short, n_short;
    logic                  r_long, n_long;
    logic                  r_double, n_double;
    logic                  r_press, n_press;

    logic r_out_valid;
    logic [3:0] r_out_data;

    logic            accept, cfg_wr, pressed;
    t_reg_idx        reg_idx;
    logic [CW-1:0]   hold_ext, ticks_ext;
    logic [WINDOW_W-1:0] gap_inc;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign reg_idx  = t_reg_idx'(paddr[3:2]);
    assign s_tready = ~r_out_valid | m_tready;
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(OUT_W-4){1'b0}}, r_out_data};

    always_comb begin
        case (reg_idx)
            REG_ACTIVE_LEVEL: prdata = {{(DATA_W-1){1'b0}}, r_active_level};
            REG_HOLD_TICKS:   prdata = {{(DATA_W-HOLD_TICKS_W){1'b0}}, r_hold_ticks};
            REG_DOUBLE_WIN:   prdata = {{(DATA_W-WINDOW_W){1'b0}}, r_double_win};
            REG_SATURATE:     prdata = {{(DATA_W-1){1'b0}}, r_saturate};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level <= RST_ACTIVE_LEVEL;
            r_hold_ticks   <= RST_HOLD_TICKS;
            r_double_win   <= RST_DOUBLE_WIN;
            r_saturate     <= RST_SATURATE;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ACTIVE_LEVEL: r_active_level <= pwdata[0];
                REG_HOLD_TICKS:   r_hold_ticks   <= pwdata[HOLD_TICKS_W-1:0];
                REG_DOUBLE_WIN:   r_double_win   <= pwdata[WINDOW_W-1:0];
                REG_SATURATE:     r_saturate     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pressed   = (s_tdata[0] == r_active_level);
        ticks_ext = CW'(r_hold_ticks);

        n_short  = r_short  & ~s_tdata[1];
        n_long   = r_long   & ~s_tdata[2];
        n_double = r_double & ~s_tdata[3];
        n_level_now = pressed;
        n_hold   = r_hold;
        n_stroke = r_stroke;
        n_lock   = r_lock;
        n_gap    = r_gap;
        n_press  = r_press;

        // hold counter stops at all ones, and past hold_ticks when saturating
        if (pressed && (r_hold != '1)
                && (!r_saturate || (CW'(r_hold) <= ticks_ext))) begin
            n_hold = r_hold + 1'b1;
        end
        hold_ext = CW'(n_hold);

        if (pressed && r_level_now) begin
            if (!r_lock && r_stroke == '0) begin
                if (hold_ext > CW'(PRESS_MIN) && hold_ext < ticks_ext) begin
                    n_press = 1'b1;
                end else if (hold_ext == ticks_ext) begin
                    n_long  = 1'b1;
                    n_press = 1'b0;
                end
            end
        end else if (!pressed && r_level_now && hold_ext < ticks_ext) begin
            // release before long press; very quick taps are ignored
            if (hold_ext > CW'(TAP_MIN)) begin
                if (!r_lock) begin
                    if (hold_ext <= CW'(PRESS_MIN)) begin
                        n_short  = 1'b0;
                        n_stroke = r_stroke + 1'b1;
                    end else begin
                        n_short  = 1'b1;
                        n_stroke = '0;
                    end
                end
                n_press = 1'b0;
            end
        end else begin
            n_hold  = '0;
            n_press = 1'b0;
            n_lock  = 1'b0;
        end

        // double click window
        gap_inc = r_gap + 1'b1;
        if (n_stroke != '0) begin
            n_gap = gap_inc;
            if (gap_inc < r_double_win) begin
                if (pressed) begin
                    n_gap = '0;
                    if (n_stroke == STROKE_W'(1)) begin
                        n_stroke = '0;
                        n_lock   = 1'b1;
                        n_double = 1'b1;
                    end
                end
            end else begin
                n_gap    = '0;
                n_stroke = '0;
                if (!n_long) begin
                    n_short = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_now <= 1'b0;
            r_hold      <= '0;
            r_stroke    <= '0;
            r_lock      <= 1'b0;
            r_gap       <= '0;
            r_short     <= 1'b0;
            r_long      <= 1'b0;
            r_double    <= 1'b0;
            r_press     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_level_now <= n_level_now;
                r_hold      <= n_hold;
                r_stroke    <= n_stroke;
                r_lock      <= n_lock;
                r_gap       <= n_gap;
                r_short     <= n_short;
                r_long      <= n_long;
                r_double    <= n_double;
                r_press     <= n_press;
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {n_press, n_double, n_long, n_short};
        end
    end

    // a double click clears the stroke count, and strokes only count unlocked
    a_lock_no_stroke: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock |-> (r_stroke == '0))
        else $error("double lock set with strokes pending");

    // gap counter only runs inside the window
    a_gap_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stroke == '0) |-> (r_gap == '0))
        else $error("gap counter running outside window");

    // every accepted word leaves a result in the output register
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (m_tvalid && m_tdata[3:0] == {r_press, r_double, r_long, r_short}))
        else $error("result register out of step with click state");

endmodule
